[rtl/bthalloc_pkg.sv]
// ----------------------------------------------------------------------------
// bthalloc_pkg: shared types and constants
// Table geometry, entry layout and result codes for the block table allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bthalloc_pkg;

  localparam int TABLE_BLOCKS = 1024;
  localparam int BLOCK_BYTES  = 4096;

  localparam int ADDR_W      = 32;
  localparam int IDX_W       = $clog2(TABLE_BLOCKS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int BCOUNT_W    = 11;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int NEED_W      = ADDR_W + 1 - BLOCK_SHIFT;
  localparam int OFF_IDX_W   = ADDR_W - BLOCK_SHIFT;
  localparam int CFG_IDX_W   = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

  // request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_e;

  // one table entry
  typedef struct packed {
    logic has_next;
    logic first;
    logic taken;
  } entry_t;

endpackage

[rtl/bthalloc_table.sv]
// ----------------------------------------------------------------------------
// bthalloc_table: block table memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bthalloc_table (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [bthalloc_pkg::IDX_W-1:0]  wr_addr_i,
  input  bthalloc_pkg::entry_t            wr_data_i,
  input  logic                            rd_en_i,
  input  logic [bthalloc_pkg::IDX_W-1:0]  rd_addr_i,
  output bthalloc_pkg::entry_t            rd_data_o
);
  import bthalloc_pkg::*;

  entry_t mem_q [TABLE_BLOCKS];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/block_table_heap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// block_table_heap_allocator_unit: fixed-block first-fit heap allocator
// Allocate finds the lowest run of free blocks and chains it; free walks the
// chain from the given block and clears it.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | beat
//  in      | in  | in_valid_i/in_ready_o  | action, request_bytes, block_address
//  out     | out | out_valid_o/out_ready_i| granted_address, status
//  cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_index (0 heap_base, 1 block_count)
//
// After reset the table is swept clear, one entry a cycle, with no input beat
// taken (cfg writes are taken throughout). Rejected requests go from accept
// straight to the response. Allocate: accept, a scan of the table (one table
// read a cycle, bounded by n, the effective block count), a mark step per
// chained block, then the response. Free: accept, a walk that reads and clears
// each chain entry, then the response. One request is in flight at a time; a
// finished result waits in a holding stage while the output register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_table_heap_allocator_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 action_i,
  input  logic [31:0]                          request_bytes_i,
  input  logic [31:0]                          block_address_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [31:0]                          granted_address_o,
  output logic [1:0]                           status_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bthalloc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                          cfg_data_i
);
  import bthalloc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_WALK,
    S_RESP
  } state_e;

  state_e               state_q, state_d;
  logic [ADDR_W-1:0]    heap_base_q;
  logic [BCOUNT_W-1:0]  blk_cnt_q;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]     chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0]     run_q, run_d;
  logic [IDX_W-1:0]     start_q, start_d;
  logic [CNT_W-1:0]     need_q, need_d;
  logic [IDX_W-1:0]     mk_idx_q, mk_idx_d;
  logic [CNT_W-1:0]     mk_left_q, mk_left_d;
  logic [IDX_W-1:0]     clr_idx_q, clr_idx_d;
  logic [ADDR_W-1:0]    res_addr_q, res_addr_d;
  status_e              res_status_q, res_status_d;
  logic                 out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]    out_addr_q, out_addr_d;
  status_e              out_status_q, out_status_d;

  logic [CNT_W-1:0]     n_eff;
  logic [NEED_W-1:0]    need_full;
  logic [ADDR_W-1:0]    offset;
  logic [OFF_IDX_W-1:0] free_idx;
  logic                 in_fire;
  logic                 issue;
  logic                 is_free;
  logic                 at_last;
  logic [CNT_W-1:0]     run_new;
  logic [IDX_W-1:0]     start_now;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;
  entry_t               rd_data;

  bthalloc_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (issue),
    .rd_addr_i (rd_idx_q[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      blk_cnt_q   <= BCOUNT_W'(TABLE_BLOCKS);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEAP_BASE:   heap_base_q <= cfg_data_i;
        CFG_BLOCK_COUNT: blk_cnt_q   <= cfg_data_i[BCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (32'(blk_cnt_q) > 32'(TABLE_BLOCKS)) ? CNT_W'(TABLE_BLOCKS)
                                                      : CNT_W'(blk_cnt_q);
  assign need_full = NEED_W'(({1'b0, request_bytes_i} + 33'(BLOCK_BYTES - 1))
                             >> BLOCK_SHIFT);
  assign offset    = block_address_i - heap_base_q;
  assign free_idx  = offset[ADDR_W-1:BLOCK_SHIFT];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // scan / walk datapath
  assign issue     = ((state_q == S_SCAN) || (state_q == S_WALK)) && (rd_idx_q < n_q);
  assign is_free   = !rd_data.taken;
  assign run_new   = is_free ? run_q + CNT_W'(1) : '0;
  assign start_now = (run_q == '0) ? chk_idx_q : start_q;
  assign at_last   = ({1'b0, chk_idx_q} == n_q - CNT_W'(1));

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    rd_idx_d     = rd_idx_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    run_d        = run_q;
    start_d      = start_q;
    need_d       = need_q;
    mk_idx_d     = mk_idx_q;
    mk_left_d    = mk_left_q;
    clr_idx_d    = clr_idx_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    wr_en        = 1'b0;
    wr_addr      = chk_idx_q;
    wr_data      = '0;

    if (issue) begin
      rd_idx_d  = rd_idx_q + CNT_W'(1);
      chk_vld_d = 1'b1;
      chk_idx_d = rd_idx_q[IDX_W-1:0];
    end

    unique case (state_q)
      S_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = clr_idx_q;
        clr_idx_d = clr_idx_q + IDX_W'(1);
        if (clr_idx_q == IDX_W'(TABLE_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          n_d          = n_eff;
          rd_idx_d     = '0;
          run_d        = '0;
          res_addr_d   = '0;
          res_status_d = ST_BAD;
          if (action_i == ACT_ALLOC) begin
            need_d = need_full[CNT_W-1:0];
            if (request_bytes_i == '0 || n_eff == '0 ||
                need_full > NEED_W'(n_eff)) begin
              state_d = S_RESP;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            rd_idx_d = free_idx[CNT_W-1:0];
            if (free_idx >= OFF_IDX_W'(n_eff)) begin
              state_d = S_RESP;
            end else begin
              state_d = S_WALK;
            end
          end
        end
      end
      S_SCAN: begin
        if (chk_vld_q) begin
          run_d = run_new;
          if (is_free) begin
            start_d = start_now;
          end
          if (is_free && run_new == need_q) begin
            mk_idx_d  = start_now;
            mk_left_d = need_q;
            state_d   = S_MARK;
          end else if (at_last) begin
            res_status_d = ST_NOSPACE;
            state_d      = S_RESP;
          end
        end
      end
      S_MARK: begin
        wr_en            = 1'b1;
        wr_addr          = mk_idx_q;
        wr_data.taken    = 1'b1;
        wr_data.first    = (mk_idx_q == start_q);
        wr_data.has_next = (mk_left_q != CNT_W'(1));
        mk_idx_d         = mk_idx_q + IDX_W'(1);
        mk_left_d        = mk_left_q - CNT_W'(1);
        if (mk_left_q == CNT_W'(1)) begin
          res_addr_d   = heap_base_q + (ADDR_W'(start_q) << BLOCK_SHIFT);
          res_status_d = ST_OK;
          state_d      = S_RESP;
        end
      end
      S_WALK: begin
        // clear the entry just read; next read is already in flight
        if (chk_vld_q) begin
          wr_en   = 1'b1;
          wr_addr = chk_idx_q;
          if (!rd_data.has_next || at_last) begin
            res_status_d = ST_OK;
            state_d      = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    rd_idx_q     <= rd_idx_d;
    chk_idx_q    <= chk_idx_d;
    run_q        <= run_d;
    start_q      <= start_d;
    need_q       <= need_d;
    mk_idx_q     <= mk_idx_d;
    mk_left_q    <= mk_left_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_status_q;

  // failures and frees never carry an address
  a_fail_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> granted_address_o == '0)
    else $error("nonzero address on failed request");

  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_NOSPACE || status_o == ST_BAD)
    else $error("illegal status code");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  a_mark_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MARK |-> {1'b0, mk_idx_q} < n_q)
    else $error("chain write beyond heap");

endmodule

[bench/alloc_grant_checker.sv]
// ----------------------------------------------------------------------------
// alloc_grant_checker: result checker for the block table allocator
// Watches the request, result and register channels, keeps its own copy of the
// block table, predicts the grant of every accepted request and compares each
// result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alloc_grant_checker
  import bthalloc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 action_i,
  input  logic [31:0]          request_bytes_i,
  input  logic [31:0]          block_address_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [31:0]          granted_address_i,
  input  logic [1:0]           status_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output int                   fail_count_o,
  output int                   due_count_o
);

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    status_e           status;
  } grant_t;

  entry_t              blocks [TABLE_BLOCKS];
  logic [ADDR_W-1:0]   base_q;
  logic [BCOUNT_W-1:0] count_q;
  grant_t              due_grants [$];

  function automatic int usable_blocks();
    return (int'(count_q) > TABLE_BLOCKS) ? TABLE_BLOCKS : int'(count_q);
  endfunction

  // first fit over contiguous free blocks, then chain the run
  function automatic grant_t grab_run(input logic [31:0] bytes);
    grant_t     g;
    int         n;
    int         run;
    int         start;
    logic [63:0] need;
    bit         found;
    n         = usable_blocks();
    g.address = '0;
    g.status  = ST_BAD;
    run       = 0;
    start     = 0;
    found     = 1'b0;
    if (bytes == '0 || n == 0) return g;
    need = ({32'd0, bytes} + 64'(BLOCK_BYTES - 1)) / 64'(BLOCK_BYTES);
    if (need > 64'(n)) return g;
    for (int i = 0; i < n && !found; i++) begin
      if (!blocks[i].taken) begin
        if (run == 0) start = i;
        run++;
        found = (64'(run) == need);
      end else begin
        run = 0;
      end
    end
    if (!found) begin
      g.status = ST_NOSPACE;
      return g;
    end
    for (int i = start; i < start + int'(need); i++) begin
      blocks[i].taken    = 1'b1;
      blocks[i].first    = (i == start);
      blocks[i].has_next = (i + 1 < start + int'(need));
    end
    g.address = base_q + 32'(start * BLOCK_BYTES);
    g.status  = ST_OK;
    return g;
  endfunction

  // clear along has-next marks from the block holding addr
  function automatic grant_t release_chain(input logic [31:0] addr);
    grant_t      g;
    int          n;
    logic [31:0] idx;
    bit          walking;
    entry_t      e;
    n         = usable_blocks();
    g.address = '0;
    g.status  = ST_BAD;
    idx       = (addr - base_q) / 32'(BLOCK_BYTES);
    if (idx >= 32'(n)) return g;
    walking = 1'b1;
    for (int i = int'(idx); i < n && walking; i++) begin
      e         = blocks[i];
      blocks[i] = '0;
      walking   = e.has_next;
    end
    g.status = ST_OK;
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      foreach (blocks[i]) blocks[i] = '0;
      base_q       = '0;
      count_q      = BCOUNT_W'(TABLE_BLOCKS);
      fail_count_o = 0;
      due_grants.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_HEAP_BASE:   base_q  = cfg_data_i;
          CFG_BLOCK_COUNT: count_q = cfg_data_i[BCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (due_grants.size() == 0) begin
          $display("%0t ns: result beat with nothing expected: address %h status %0d",
                   $time, granted_address_i, status_i);
          fail_count_o++;
        end else begin
          want = due_grants.pop_front();
          if (granted_address_i != want.address) begin
            $display("%0t ns: granted_address expected %h actual %h",
                     $time, want.address, granted_address_i);
            fail_count_o++;
          end
          if (status_i != want.status) begin
            $display("%0t ns: status expected %0d actual %0d",
                     $time, want.status, status_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (action_i == ACT_ALLOC) due_grants.push_back(grab_run(request_bytes_i));
        else due_grants.push_back(release_chain(block_address_i));
      end
    end
    due_count_o = due_grants.size();
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: block table allocator testbench
// Directed allocate/free cases, then randomized request mixes under several
// heap settings and handshake idling patterns; results are checked by
// alloc_grant_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bthalloc_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 action_i        = ACT_ALLOC;
  logic [31:0]          request_bytes_i = '0;
  logic [31:0]          block_address_i = '0;
  logic                 out_ready_i     = 1'b0;
  logic                 cfg_valid_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i     = CFG_HEAP_BASE;
  logic [31:0]          cfg_data_i      = '0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [31:0]          granted_address_o;
  logic [1:0]           status_o;
  logic                 cfg_ready_o;

  int          fail_count;
  int          due_count;
  idle_e       idle_mode = IDLE_NONE;
  logic [31:0] cur_base  = '0;
  int          cur_live  = TABLE_BLOCKS;
  int          rand_items = 0;

  always #2 clk_i = ~clk_i;

  block_table_heap_allocator_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .request_bytes_i,
    .block_address_i, .out_valid_o, .out_ready_i, .granted_address_o, .status_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  alloc_grant_checker grant_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .action_i,
    .request_bytes_i, .block_address_i, .out_valid_i(out_valid_o), .out_ready_i,
    .granted_address_i(granted_address_o), .status_i(status_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .due_count_o(due_count)
  );

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    case (idle_mode)
      IDLE_RECV: out_ready_i <= ($urandom_range(99) >= 54);
      IDLE_BOTH: out_ready_i <= ($urandom_range(99) >= 11);
      default:   out_ready_i <= 1'b1;
    endcase
  end

  task automatic send_request(input logic act, input logic [31:0] bytes,
                              input logic [31:0] addr);
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 54 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    if ($urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    request_bytes_i <= bytes;
    block_address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic alloc_req(input logic [31:0] bytes);
    send_request(ACT_ALLOC, bytes, $urandom);
  endtask

  task automatic free_req(input logic [31:0] addr);
    send_request(ACT_FREE, $urandom, addr);
  endtask

  // sample at the falling edge so the checker's update of this edge is seen
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (due_count != 0);
    @(posedge clk_i);
  endtask

  task automatic set_heap(input logic [31:0] base, input int count);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_HEAP_BASE;
    cfg_data_i  <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_BLOCK_COUNT;
    cfg_data_i  <= 32'(count);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_base = base;
    cur_live = (count > TABLE_BLOCKS) ? TABLE_BLOCKS : count;
  endtask

  task automatic random_item();
    int          r;
    int          need;
    int          idx;
    int          span;
    logic [31:0] off;
    r = $urandom_range(99);
    idle_mode = idle_e'((rand_items / 30) % 4);
    rand_items++;
    if (cur_live == 0 || r < 6) begin
      case ($urandom_range(3))
        0: alloc_req('0);
        1: alloc_req($urandom);
        2: free_req($urandom);
        default: free_req(cur_base + 32'((cur_live + $urandom_range(0, 7)) * BLOCK_BYTES));
      endcase
    end else if (r < 56) begin
      // mostly short runs, now and then up to the whole heap
      if ($urandom_range(19) == 0) need = $urandom_range(1, cur_live);
      else need = $urandom_range(1, (cur_live < 4) ? cur_live : 4);
      alloc_req(32'((need - 1) * BLOCK_BYTES) + 32'($urandom_range(1, BLOCK_BYTES)));
    end else begin
      span = (cur_live < 48) ? cur_live : 48;
      idx  = ($urandom_range(9) == 0) ? $urandom_range(0, cur_live - 1)
                                      : $urandom_range(0, span - 1);
      off  = ($urandom_range(3) == 0) ? 32'($urandom_range(0, BLOCK_BYTES - 1)) : '0;
      free_req(cur_base + 32'(idx * BLOCK_BYTES) + off);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: base 0, full table
    alloc_req('0);
    alloc_req(32'hFFFF_FFFF);
    alloc_req(32'd1);
    alloc_req(32'(BLOCK_BYTES));
    alloc_req(32'(BLOCK_BYTES + 1));
    free_req(32'(2 * BLOCK_BYTES + 5));   // unaligned, inside a run head
    free_req(32'(BLOCK_BYTES));
    free_req(32'(BLOCK_BYTES));           // already free
    free_req(32'hFFFF_FFFF);
    free_req('0);
    alloc_req(32'(TABLE_BLOCKS * BLOCK_BYTES));
    alloc_req(32'd1);                     // table full
    free_req(32'(3 * BLOCK_BYTES));       // middle of the run
    alloc_req(32'(3 * BLOCK_BYTES));
    free_req('0);

    // heap at the top of the address space, granted address wraps
    set_heap(32'hFFFF_F000, 4);
    alloc_req(32'(BLOCK_BYTES));
    alloc_req(32'(2 * BLOCK_BYTES));
    alloc_req(32'(5 * BLOCK_BYTES));
    free_req('0);
    free_req(32'hFFFF_EFFF);

    set_heap(32'h0000_0000, 0);
    alloc_req(32'd1);
    free_req('0);

    set_heap(32'($urandom_range(0, 32'hF_FFFF) << 12), 16);
    repeat (120) random_item();
    set_heap(32'hFFFF_C000, 8);
    repeat (100) random_item();
    set_heap(32'hFFFF_FFFF, 1);
    repeat (60) random_item();
    set_heap(32'h0000_0000, 2047);
    repeat (100) random_item();
    set_heap($urandom, 32);
    repeat (150) random_item();
    set_heap($urandom, 0);
    repeat (20) random_item();

    drain();
    repeat (2100) @(posedge clk_i);
    if (fail_count == 0 && due_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[block_table_heap_allocator_unit.f]
rtl/bthalloc_pkg.sv
rtl/bthalloc_table.sv
rtl/block_table_heap_allocator_unit.sv
bench/alloc_grant_checker.sv
bench/tb.sv
